// ===== src/pcx_pkg.sv =====
// ----------------------------------------------------------------------------
// pcx_pkg
// Shared types and character helpers for the percent/hex byte codec.
// ----------------------------------------------------------------------------
package pcx_pkg;

    // codec_mode register codes; code 3 behaves as hex-all
    typedef enum logic [1:0] {
        MODE_DECODE = 2'd0,
        MODE_ENCODE = 2'd1,
        MODE_HEX    = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,   // no escape pending
        PH_PCT  = 2'd1,   // '%' seen
        PH_HIGH = 2'd2    // first digit seen
    } phase_t;

    localparam int unsigned MaxResults = 3;
    localparam logic [7:0]  CharPct    = 8'h25;

    typedef struct packed {
        logic [1:0] phase;
        logic [3:0] nibble;
    } esc_t;

    // results caused by one input byte, slot 0 goes out first
    typedef struct packed {
        logic [1:0]                 count;
        logic [MaxResults-1:0][7:0] bytes;
        logic                       marker;   // empty end result
        logic                       last;
    } grp_t;

    function automatic logic [3:0] digit_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c inside {["0":"9"]})
            v = c[3:0];
        else if (c inside {["A":"F"], ["a":"f"]})
            v = c[3:0] + 4'd9;
        return v;
    endfunction

    function automatic logic is_safe(input logic [7:0] c);
        return c inside {["a":"z"], ["A":"Z"], ["0":"9"], ".", "/", "-", "_", "$"};
    endfunction

    // lowercase hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] ch;
        if (n < 4'd10)
            ch = 8'h30 + {4'd0, n};
        else
            ch = 8'h57 + {4'd0, n};
        return ch;
    endfunction

endpackage

// ===== src/pcx_xlate.sv =====
// ----------------------------------------------------------------------------
// pcx_xlate
// Translates one input byte into its result group and the next escape state.
// ----------------------------------------------------------------------------
module pcx_xlate
    import pcx_pkg::*;
(
    input  logic [1:0] mode,
    input  esc_t       esc,
    input  logic [7:0] data_byte,
    input  logic       last_in,
    output grp_t       grp,
    output esc_t       esc_next
);

    always_comb
    begin
        grp      = '0;
        esc_next = esc;

        case (mode)
            MODE_DECODE:
            begin
                if (esc.phase == PH_PCT)
                begin
                    esc_next.nibble = digit_value(data_byte);
                    esc_next.phase  = PH_HIGH;
                end
                else if (esc.phase == PH_HIGH)
                begin
                    grp.count    = 2'd1;
                    grp.bytes[0] = {esc.nibble, digit_value(data_byte)};
                    esc_next     = '{phase: PH_IDLE, nibble: 4'd0};
                end
                else if (data_byte == CharPct)
                begin
                    esc_next.phase = PH_PCT;
                end
                else
                begin
                    esc_next.phase = PH_IDLE;
                    grp.count      = 2'd1;
                    grp.bytes[0]   = data_byte;
                end
            end
            MODE_ENCODE:
            begin
                esc_next = '{phase: PH_IDLE, nibble: 4'd0};
                if (is_safe(data_byte))
                begin
                    grp.count    = 2'd1;
                    grp.bytes[0] = data_byte;
                end
                else
                begin
                    grp.count    = 2'd3;
                    grp.bytes[0] = CharPct;
                    grp.bytes[1] = hex_char(data_byte[7:4]);
                    grp.bytes[2] = hex_char(data_byte[3:0]);
                end
            end
            default:
            begin
                esc_next     = '{phase: PH_IDLE, nibble: 4'd0};
                grp.count    = 2'd2;
                grp.bytes[0] = hex_char(data_byte[7:4]);
                grp.bytes[1] = hex_char(data_byte[3:0]);
            end
        endcase

        // end of string drops a pending escape, empty marker if nothing came out
        if (last_in)
        begin
            esc_next = '{phase: PH_IDLE, nibble: 4'd0};
            grp.last = 1'b1;
            if (grp.count == 2'd0)
            begin
                grp.count  = 2'd1;
                grp.marker = 1'b1;
            end
        end
    end

endmodule

// ===== src/percent_hex_codec_core.sv =====
// ----------------------------------------------------------------------------
// percent_hex_codec_core
// Percent decode / percent encode / hex-all byte stream codec.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------
//  in       | in_valid / in_ready   | data_byte[7:0], last_in
//  out      | out_valid / out_ready | out_byte[7:0], byte_valid, last_out
//  cfg      | cfg_wr_en             | cfg_wr_data[1:0] (codec_mode)
//
// One input byte per cycle while in_ready is high; its results (0 to 3) are
// loaded into a 3-slot result register in the same cycle and drained one per
// cycle while out_ready is high. A byte giving several results holds off the
// next transfer until its final result leaves.
// in_ready is high when the result register is empty or its final slot
// leaves this cycle; out_ready low stalls the input side only through that.
// Reset clears the mode to decode, the escape state and the result count.
// ----------------------------------------------------------------------------
module percent_hex_codec_core
    import pcx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data,

    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       last_in,

    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       last_out
);

    logic [1:0] mode_reg;
    esc_t       esc_reg;
    esc_t       esc_next;
    grp_t       grp;

    logic [1:0]                 cnt_reg;
    logic [1:0]                 cnt_next;
    logic [MaxResults-1:0][7:0] slot_reg;
    logic [MaxResults-1:0][7:0] slot_next;
    logic                       marker_reg;
    logic                       marker_next;
    logic                       last_reg;
    logic                       last_next;

    logic in_xfer;
    logic out_xfer;
    logic load;

    pcx_xlate u_xlate (
        .mode      (mode_reg),
        .esc       (esc_reg),
        .data_byte (data_byte),
        .last_in   (last_in),
        .grp       (grp),
        .esc_next  (esc_next)
    );

    assign out_valid  = (cnt_reg != 2'd0);
    assign in_ready   = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_ready);
    assign in_xfer    = in_valid && in_ready;
    assign out_xfer   = out_valid && out_ready;
    assign load       = in_xfer && (grp.count != 2'd0);

    assign out_byte   = slot_reg[0];
    assign byte_valid = !marker_reg;
    assign last_out   = last_reg && (cnt_reg == 2'd1);

    always_comb
    begin
        cnt_next    = cnt_reg;
        slot_next   = slot_reg;
        marker_next = marker_reg;
        last_next   = last_reg;
        if (load)
        begin
            cnt_next    = grp.count;
            slot_next   = grp.bytes;
            marker_next = grp.marker;
            last_next   = grp.last;
        end
        else if (out_xfer)
        begin
            cnt_next  = cnt_reg - 2'd1;
            slot_next = {8'd0, slot_reg[MaxResults-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_DECODE;
            esc_reg  <= '{phase: PH_IDLE, nibble: 4'd0};
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (cfg_wr_en)
                mode_reg <= cfg_wr_data;
            if (in_xfer)
                esc_reg <= esc_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg   <= slot_next;
        marker_reg <= marker_next;
        last_reg   <= last_next;
    end

`ifndef ASSERT_OFF
    // empty end marker is always a lone, final result
    a_marker_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && marker_reg) |-> (cnt_reg == 2'd1) && last_reg)
        else $error("empty end marker not a single final result");

    a_last_clears_esc: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && last_in) |=> (esc_reg.phase == PH_IDLE) && (esc_reg.nibble == 4'd0))
        else $error("escape state survives end of string");

    a_encode_clears_esc: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (mode_reg != MODE_DECODE)) |=> (esc_reg.phase == PH_IDLE))
        else $error("escape pending after encode step");

    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && (cnt_reg == 2'd1) && !load) |=> !out_valid)
        else $error("result register not empty after final slot left");
`endif

endmodule
